[design/odd_even_transposition_sorter_assert.svh]
// ----------------------------------------------------------------------------
// odd_even_transposition_sorter_assert.svh
// assertion macros shared by the sorter rtl
// ----------------------------------------------------------------------------
`ifndef ODD_EVEN_TRANSPOSITION_SORTER_ASSERT_SVH
`define ODD_EVEN_TRANSPOSITION_SORTER_ASSERT_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge outside reset
`define OETS_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("sorter assertion failed");

// expression must never be true outside reset
`define OETS_ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("sorter forbidden condition seen");

`else

`define OETS_ASSERT(lbl, clk, rst_n, prop)
`define OETS_ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

[design/oets_pkg.sv]
// ----------------------------------------------------------------------------
// oets_pkg
// shared types and constants of the odd-even transposition sorter
// ----------------------------------------------------------------------------
package oets_pkg;

	localparam int DEPTH_DEF     = 16;
	localparam int KEY_WIDTH_DEF = 32;

	// cell operations
	localparam logic [1:0] OP_HOLD = 2'd0;
	localparam logic [1:0] OP_LOAD = 2'd1;
	localparam logic [1:0] OP_SORT = 2'd2;
	localparam logic [1:0] OP_EMIT = 2'd3;

	typedef struct packed {
		logic [1:0] op;
		logic       odd_phase;
	} cell_ctrl_t;

endpackage

[design/oets_cell.sv]
// ----------------------------------------------------------------------------
// oets_cell
// one key slot of the sorting chain: shift in, compare-swap, shift out
// ----------------------------------------------------------------------------
module oets_cell #(
	parameter int KEY_WIDTH = oets_pkg::KEY_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  oets_pkg::cell_ctrl_t        ctrl,
	input  logic                        pos_odd,
	input  logic signed [KEY_WIDTH-1:0] lo_key,
	input  logic                        lo_valid,
	input  logic signed [KEY_WIDTH-1:0] hi_key,
	input  logic                        hi_valid,
	output logic signed [KEY_WIDTH-1:0] key_q,
	output logic                        valid_q
);

	logic                        is_left;
	logic signed [KEY_WIDTH-1:0] partner_key;
	logic                        partner_valid;
	logic                        greater;
	logic                        swap;

	always_comb begin
		// left member of the pair keeps the smaller key
		is_left       = (pos_odd == ctrl.odd_phase);
		partner_key   = is_left ? hi_key : lo_key;
		partner_valid = is_left ? hi_valid : lo_valid;
		greater       = is_left ? (key_q > hi_key) : (lo_key > key_q);
		swap          = valid_q & partner_valid & greater;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			case (ctrl.op)
				oets_pkg::OP_LOAD: valid_q <= lo_valid;
				oets_pkg::OP_EMIT: valid_q <= hi_valid;
				default:           valid_q <= valid_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctrl.op)
			oets_pkg::OP_LOAD: key_q <= lo_key;
			oets_pkg::OP_EMIT: key_q <= hi_key;
			oets_pkg::OP_SORT: begin
				if (swap) key_q <= partner_key;
			end
			default: key_q <= key_q;
		endcase
	end

endmodule

[design/odd_even_transposition_sorter.sv]
// ----------------------------------------------------------------------------
// odd_even_transposition_sorter
// collects a set of signed keys into a chain of cells, sorts it by
// odd-even transposition and sends the keys out in ascending order
// ----------------------------------------------------------------------------
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------------------
//  input    | key_valid / key_stall     | key, last_key
//  output   | result_valid/result_stall | sorted_key, end_of_run, overflowed
//
//  a set of n keys is loaded one key per transfer, sorted in n compare-swap
//  phases (one phase per cycle across the whole chain) and emitted one
//  key per transfer. key_stall is high while a set is sorted or emitted.
//  result stalls hold the chain; after reset the block waits for keys.
// ----------------------------------------------------------------------------
module odd_even_transposition_sorter #(
	parameter int DEPTH     = oets_pkg::DEPTH_DEF,
	parameter int KEY_WIDTH = oets_pkg::KEY_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        key_valid,
	output logic                        key_stall,
	input  logic signed [KEY_WIDTH-1:0] key,
	input  logic                        last_key,
	output logic                        result_valid,
	input  logic                        result_stall,
	output logic signed [KEY_WIDTH-1:0] sorted_key,
	output logic                        end_of_run,
	output logic                        overflowed
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	localparam logic [1:0] ST_LOAD = 2'd0;
	localparam logic [1:0] ST_SORT = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] phase_q;
	logic             dropped_q;

	logic                        in_xfer;
	logic                        out_xfer;
	logic                        full;
	oets_pkg::cell_ctrl_t        ctrl;
	logic signed [KEY_WIDTH-1:0] cell_key [DEPTH];
	logic [DEPTH-1:0]            cell_valid;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign in_xfer  = key_valid && !key_stall;
	assign out_xfer = result_valid && !result_stall;

	assign key_stall    = (state_q != ST_LOAD);
	assign result_valid = (state_q == ST_EMIT);
	assign sorted_key   = cell_key[0];
	assign end_of_run   = !cell_valid[1];
	assign overflowed   = dropped_q;

	always_comb begin
		ctrl.odd_phase = phase_q[0];
		ctrl.op        = oets_pkg::OP_HOLD;
		case (state_q)
			ST_LOAD: if (in_xfer && !full) ctrl.op = oets_pkg::OP_LOAD;
			ST_SORT: ctrl.op = oets_pkg::OP_SORT;
			ST_EMIT: if (out_xfer) ctrl.op = oets_pkg::OP_EMIT;
			default: ctrl.op = oets_pkg::OP_HOLD;
		endcase
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [KEY_WIDTH-1:0] lo_key;
		logic                        lo_valid;
		logic signed [KEY_WIDTH-1:0] hi_key;
		logic                        hi_valid;

		if (i == 0) begin : g_first
			// new keys enter at the bottom of the chain
			assign lo_key   = key;
			assign lo_valid = (state_q == ST_LOAD);
		end else begin : g_mid_lo
			assign lo_key   = cell_key[i-1];
			assign lo_valid = cell_valid[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign hi_key   = cell_key[i];
			assign hi_valid = 1'b0;
		end else begin : g_mid_hi
			assign hi_key   = cell_key[i+1];
			assign hi_valid = cell_valid[i+1];
		end

		oets_cell #(
			.KEY_WIDTH(KEY_WIDTH)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (ctrl),
			.pos_odd (1'(i % 2)),
			.lo_key  (lo_key),
			.lo_valid(lo_valid),
			.hi_key  (hi_key),
			.hi_valid(hi_valid),
			.key_q   (cell_key[i]),
			.valid_q (cell_valid[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			count_q   <= '0;
			phase_q   <= '0;
			dropped_q <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (in_xfer) begin
						if (full) dropped_q <= 1'b1;
						else      count_q   <= count_q + 1'b1;
						if (last_key) begin
							state_q <= ST_SORT;
							phase_q <= '0;
						end
					end
				end
				ST_SORT: begin
					// one phase per held key
					if (phase_q == count_q - 1'b1) state_q <= ST_EMIT;
					else                           phase_q <= phase_q + 1'b1;
				end
				ST_EMIT: begin
					if (out_xfer && end_of_run) begin
						state_q   <= ST_LOAD;
						count_q   <= '0;
						dropped_q <= 1'b0;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

`include "odd_even_transposition_sorter_assert.svh"

	// held keys always fill the bottom of the chain without gaps
	`OETS_ASSERT_NEVER(a_valid_gap, clk, arst_n, (cell_valid & (cell_valid + 1'b1)) != '0)
	`OETS_ASSERT(a_emit_has_key, clk, arst_n, result_valid |-> cell_valid[0])
	`OETS_ASSERT(a_count_bound, clk, arst_n, count_q <= CNT_W'(DEPTH))
	`OETS_ASSERT(a_drop_flags, clk, arst_n, (in_xfer && full) |=> dropped_q)
	`OETS_ASSERT(a_sort_nonempty, clk, arst_n, (state_q == ST_SORT) |-> (count_q != '0))
	`OETS_ASSERT(a_count_matches, clk, arst_n,
		(state_q == ST_SORT) |-> ($countones(cell_valid) == int'(count_q)))

endmodule
